[sv/psw_pkg.sv]
// ----------------------------------------------------------------------------
// psw_pkg
// Shared types and constants for the planar span write mask generator:
// edge mask tables, field widths, register indexes and the decoded span word.
// ----------------------------------------------------------------------------
`default_nettype none

package psw_pkg;

  // Field widths
  localparam int ADDR_W   = 16;
  localparam int MASK_W   = 4;
  localparam int COUNT_W  = 10;
  localparam int COLOR_W  = 8;
  localparam int X_W      = 10;
  localparam int Y_W      = 8;
  localparam int WIDTH_W  = 10;
  localparam int LW_W     = 9;
  localparam int PROD_W   = Y_W + LW_W;
  // Byte distance from first to last byte of a span (0 to 256)
  localparam int DIFF_W   = 9;
  // Pixel end column x + w - 1 (up to 2045)
  localparam int END_W    = 11;
  // Scan line compare width, holds MAX_LINES up to 2047
  localparam int LINE_CMP_W = 11;

  // Configuration port
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUFFER_OFFSET = 1'b0,
    CFG_LINE_WIDTH    = 1'b1
  } cfg_idx_t;

  localparam logic [ADDR_W-1:0] BUFFER_OFFSET_RST = 16'd0;
  localparam logic [LW_W-1:0]   LINE_WIDTH_RST    = 9'd80;

  localparam int MAX_LINES_DEF = 256;

  // Plane masks for the left and right edge byte, indexed by pixel & 3
  typedef logic [MASK_W-1:0] mask_tbl_t [4];
  localparam mask_tbl_t LEFT_EDGE  = '{4'd15, 4'd14, 4'd12, 4'd8};
  localparam mask_tbl_t RIGHT_EDGE = '{4'd1, 4'd3, 4'd7, 4'd15};
  localparam logic [MASK_W-1:0] FULL_MASK = 4'd15;

  // Decoded span, handed from the decode logic to the command sequencer
  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [MASK_W-1:0]  lmask;
    logic [MASK_W-1:0]  rmask;
    logic [DIFF_W-1:0]  diff;
    logic [COLOR_W-1:0] color;
  } span_t;

endpackage

`default_nettype wire

[sv/psw_span_decode.sv]
// ----------------------------------------------------------------------------
// psw_span_decode
// Decodes one registered span into its first byte address, edge masks and
// byte distance; flags spans that produce no commands.
// ----------------------------------------------------------------------------
`default_nettype none

module psw_span_decode #(
  parameter int MAX_LINES = psw_pkg::MAX_LINES_DEF
) (
  input  wire logic [psw_pkg::X_W-1:0]     span_x,
  input  wire logic [psw_pkg::Y_W-1:0]     span_y,
  input  wire logic [psw_pkg::WIDTH_W-1:0] span_width,
  input  wire logic [psw_pkg::COLOR_W-1:0] fill_color,
  input  wire logic [psw_pkg::ADDR_W-1:0]  buffer_offset,
  input  wire logic [psw_pkg::LW_W-1:0]    line_width,
  output psw_pkg::span_t                   span,
  output logic                             drop
);

  logic [psw_pkg::END_W-1:0]  end_px;
  logic [psw_pkg::PROD_W-1:0] row_prod;
  logic [psw_pkg::DIFF_W-1:0] x_byte;
  logic [psw_pkg::DIFF_W-1:0] end_byte;

  // Drop empty spans and scan lines past the frame
  assign drop = (span_width == '0) ||
                (psw_pkg::LINE_CMP_W'(span_y) >= psw_pkg::LINE_CMP_W'(MAX_LINES));

  // Last pixel column and byte positions
  assign end_px   = psw_pkg::END_W'(span_x) + psw_pkg::END_W'(span_width)
                    - psw_pkg::END_W'(1);
  assign x_byte   = psw_pkg::DIFF_W'(span_x[psw_pkg::X_W-1:2]);
  assign end_byte = end_px[psw_pkg::END_W-1:2];

  // Row start: offset + y * line_width + x / 4, wrapping at 16 bits
  assign row_prod = psw_pkg::PROD_W'(span_y) * psw_pkg::PROD_W'(line_width);

  always_comb begin
    span.base  = buffer_offset + row_prod[psw_pkg::ADDR_W-1:0]
                 + psw_pkg::ADDR_W'(x_byte);
    span.lmask = psw_pkg::LEFT_EDGE[span_x[1:0]];
    span.rmask = psw_pkg::RIGHT_EDGE[end_px[1:0]];
    span.diff  = end_byte - x_byte;
    span.color = fill_color;
  end

endmodule

`default_nettype wire

[sv/psw_cmd_seq.sv]
// ----------------------------------------------------------------------------
// psw_cmd_seq
// Holds one decoded span and steps it through the left, middle and right
// commands it needs, one per cycle unless stalled, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psw_cmd_seq (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         span_valid,
  input  wire psw_pkg::span_t               span,
  output logic                              span_ready,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [psw_pkg::ADDR_W-1:0]        out_write_address,
  output logic [psw_pkg::MASK_W-1:0]        out_plane_mask,
  output logic [psw_pkg::COUNT_W-1:0]       out_byte_count,
  output logic [psw_pkg::COLOR_W-1:0]       out_write_color,
  output logic                              out_last_command
);

  typedef enum logic [1:0] {
    PH_LEFT,
    PH_MID,
    PH_RIGHT
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic                          hold_valid_r;
  psw_pkg::span_t                hold_r;
  logic                          out_valid_r;
  logic [psw_pkg::ADDR_W-1:0]    addr_r;
  logic [psw_pkg::MASK_W-1:0]    mask_r;
  logic [psw_pkg::COUNT_W-1:0]   count_r;
  logic [psw_pkg::COLOR_W-1:0]   color_r;
  logic                          last_r;

  logic                          out_free;
  logic                          emit;
  logic                          single;
  logic                          is_last;
  logic [psw_pkg::ADDR_W-1:0]    addr_step;
  logic [psw_pkg::ADDR_W-1:0]    cmd_addr;
  logic [psw_pkg::MASK_W-1:0]    cmd_mask;
  logic [psw_pkg::COUNT_W-1:0]   cmd_count;

  // Handshake between held span and output register
  assign out_free   = !out_valid_r || !out_stall;
  assign emit       = hold_valid_r && out_free;
  assign single     = (hold_r.diff == '0);
  assign is_last    = (phase_r == PH_RIGHT) || ((phase_r == PH_LEFT) && single);
  assign span_ready = !hold_valid_r || (out_free && is_last);

  // Build the command for the current phase
  always_comb begin
    unique case (phase_r)
      PH_LEFT: begin
        addr_step = '0;
        cmd_mask  = single ? (hold_r.lmask & hold_r.rmask) : hold_r.lmask;
        cmd_count = psw_pkg::COUNT_W'(1);
        phase_nxt = (hold_r.diff > psw_pkg::DIFF_W'(1)) ? PH_MID : PH_RIGHT;
      end
      PH_MID: begin
        addr_step = psw_pkg::ADDR_W'(1);
        cmd_mask  = psw_pkg::FULL_MASK;
        cmd_count = psw_pkg::COUNT_W'(hold_r.diff - psw_pkg::DIFF_W'(1));
        phase_nxt = PH_RIGHT;
      end
      PH_RIGHT: begin
        addr_step = psw_pkg::ADDR_W'(hold_r.diff);
        cmd_mask  = hold_r.rmask;
        cmd_count = psw_pkg::COUNT_W'(1);
        phase_nxt = PH_RIGHT;
      end
      default: begin
        addr_step = '0;
        cmd_mask  = hold_r.lmask;
        cmd_count = psw_pkg::COUNT_W'(1);
        phase_nxt = PH_LEFT;
      end
    endcase
    cmd_addr = hold_r.base + addr_step;
  end

  // Hold the span, advance the phase and load the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEFT;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (span_valid && span_ready) begin
        hold_r       <= span;
        hold_valid_r <= 1'b1;
        phase_r      <= PH_LEFT;
      end else if (emit && is_last) begin
        hold_valid_r <= 1'b0;
      end else if (emit) begin
        phase_r <= phase_nxt;
      end

      if (out_free) begin
        out_valid_r <= hold_valid_r;
      end
      if (emit) begin
        addr_r  <= cmd_addr;
        mask_r  <= cmd_mask;
        count_r <= cmd_count;
        color_r <= hold_r.color;
        last_r  <= is_last;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_address = addr_r;
  assign out_plane_mask    = mask_r;
  assign out_byte_count    = count_r;
  assign out_write_color   = color_r;
  assign out_last_command  = last_r;

  // A middle phase only exists for spans with an inner byte run
  a_mid_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid_r && phase_r == PH_MID) |-> (hold_r.diff > psw_pkg::DIFF_W'(1)))
    else $error("middle phase on a span without inner bytes");

  // The right edge phase never belongs to a single-byte span
  a_right_not_single: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid_r && phase_r == PH_RIGHT) |-> !single)
    else $error("right edge phase on a single-byte span");

  // Every shown command writes at least one plane and one byte
  a_cmd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (mask_r != '0 && count_r != '0))
    else $error("empty write command");

  // A new span is taken only once the held one has finished
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (span_valid && span_ready && hold_valid_r) |-> (emit && is_last))
    else $error("held span replaced before its last command");

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

endmodule

`default_nettype wire

[sv/planar_span_write_mask_generator_core.sv]
// A span word is taken into the input register, decoded, held in the command
// sequencer and shown from its output register; further commands of the same
// span (left edge, middle run, right edge) follow one per cycle unless the
// output stalls. The input register can take another span word meanwhile.
// Reset: synchronous, active low; clears all valids, sets buffer_offset to 0
// and line_width to 80.
// ----------------------------------------------------------------------------
// planar_span_write_mask_generator_core
// Turns horizontal fill spans on a four-plane frame into byte write commands
// with plane masks: input register, span decode, command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_span_write_mask_generator_core #(
  parameter int MAX_LINES = psw_pkg::MAX_LINES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Configuration
  input  wire logic                             cfg_wr_en,
  input  wire logic [psw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [psw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // Span input
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [psw_pkg::X_W-1:0]          in_span_x,
  input  wire logic [psw_pkg::Y_W-1:0]          in_span_y,
  input  wire logic [psw_pkg::WIDTH_W-1:0]      in_span_width,
  input  wire logic [psw_pkg::COLOR_W-1:0]      in_fill_color,
  // Command output
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [psw_pkg::ADDR_W-1:0]            out_write_address,
  output logic [psw_pkg::MASK_W-1:0]            out_plane_mask,
  output logic [psw_pkg::COUNT_W-1:0]           out_byte_count,
  output logic [psw_pkg::COLOR_W-1:0]           out_write_color,
  output logic                                  out_last_command
);

  logic [psw_pkg::ADDR_W-1:0]   buffer_offset_r;
  logic [psw_pkg::LW_W-1:0]     line_width_r;

  logic                         in_valid_r;
  logic [psw_pkg::X_W-1:0]      span_x_r;
  logic [psw_pkg::Y_W-1:0]      span_y_r;
  logic [psw_pkg::WIDTH_W-1:0]  span_width_r;
  logic [psw_pkg::COLOR_W-1:0]  fill_color_r;

  psw_pkg::span_t               span;
  logic                         drop;
  logic                         span_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_offset_r <= psw_pkg::BUFFER_OFFSET_RST;
      line_width_r    <= psw_pkg::LINE_WIDTH_RST;
    end else if (cfg_wr_en) begin
      unique case (psw_pkg::cfg_idx_t'(cfg_index))
        psw_pkg::CFG_BUFFER_OFFSET: buffer_offset_r <= cfg_wdata;
        psw_pkg::CFG_LINE_WIDTH:    line_width_r    <= cfg_wdata[psw_pkg::LW_W-1:0];
        default: ;
      endcase
    end
  end

  // Stall only while a live span waits for the sequencer
  assign in_stall = in_valid_r && !drop && !span_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r   <= in_valid;
      span_x_r     <= in_span_x;
      span_y_r     <= in_span_y;
      span_width_r <= in_span_width;
      fill_color_r <= in_fill_color;
    end
  end

  psw_span_decode #(
    .MAX_LINES (MAX_LINES)
  ) u_decode (
    .span_x        (span_x_r),
    .span_y        (span_y_r),
    .span_width    (span_width_r),
    .fill_color    (fill_color_r),
    .buffer_offset (buffer_offset_r),
    .line_width    (line_width_r),
    .span          (span),
    .drop          (drop)
  );

  psw_cmd_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .span_valid        (in_valid_r && !drop),
    .span              (span),
    .span_ready        (span_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_write_address (out_write_address),
    .out_plane_mask    (out_plane_mask),
    .out_byte_count    (out_byte_count),
    .out_write_color   (out_write_color),
    .out_last_command  (out_last_command)
  );

endmodule

`default_nettype wire
